// ----- hdl/assert_macros.svh -----
// assertion macros shared by the stack unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// check with reset masking
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in %m");
// check that also runs through reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed in %m");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hdl/lswp_pkg.sv -----
// shared constants, codes and types of the lifo stack unit
`default_nettype none
package lswp_pkg;

   localparam int DEPTH       = 64;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   localparam int DATA_BITS   = 32;
   localparam int CAP_BITS    = 7;
   localparam int POS_BITS    = 7;
   localparam int REQ_BITS    = 2;
   localparam int STATUS_BITS = 2;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_PUSH = 2'd0,
      REQ_POP  = 2'd1,
      REQ_PEEK = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BAD_POS   = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic respond;
   } ctrl_cmd_type;

endpackage
`default_nettype wire

// ----- hdl/lifo_stack_with_peek_unit.sv -----
// lifo stack with peek: top level joining sequencer and datapath
//
//   channel   handshake                 beat
//   request   start, busy               req_type, req_push_value, req_position
//   result    rsp_valid (strobe)        rsp_read_value .. rsp_top_value
//   capacity  csr_valid, csr_ready      csr_data
//
// a request passes through accept, store access and result beat
// the store has one write port and two registered read ports
// busy stays high from the accept edge through the result cycle
// reset empties the stack and sets capacity to 64; the store itself is not cleared
// the result beat is shown for one cycle and cannot be stalled
`default_nettype none
module lifo_stack_with_peek_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  [lswp_pkg::REQ_BITS-1:0]         req_type,
   input  wire  signed [lswp_pkg::DATA_BITS-1:0] req_push_value,
   input  wire  [lswp_pkg::POS_BITS-1:0]         req_position,
   output logic                                  rsp_valid,
   output logic signed [lswp_pkg::DATA_BITS-1:0] rsp_read_value,
   output logic [lswp_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [lswp_pkg::CNT_BITS-1:0]         rsp_count,
   output logic                                  rsp_full_res,
   output logic                                  rsp_empty_res,
   output logic signed [lswp_pkg::DATA_BITS-1:0] rsp_top_value,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [lswp_pkg::CAP_BITS-1:0]         csr_data
);

   lswp_pkg::ctrl_cmd_type cmd;

   lswp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lswp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .req_position   (req_position),
      .cap_write      (csr_valid && csr_ready),
      .cap_data       (csr_data),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_full_res   (rsp_full_res),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_top_value  (rsp_top_value)
   );

   assign rsp_valid = cmd.respond;
   assign csr_ready = !busy;

endmodule
`default_nettype wire

// ----- hdl/lswp_ctrl.sv -----
// request sequencer of the lifo stack unit
`default_nettype none
`include "assert_macros.svh"
module lswp_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   output lswp_pkg::ctrl_cmd_type cmd
);

   lswp_pkg::state_type state_ff;
   lswp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lswp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b1;
      cmd.load    = 1'b0;
      cmd.exec    = 1'b0;
      cmd.respond = 1'b0;
      case (state_ff)
         lswp_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = lswp_pkg::S_EXEC;
            end
         end
         lswp_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = lswp_pkg::S_RESP;
         end
         lswp_pkg::S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = lswp_pkg::S_IDLE;
         end
         default: begin
            state_in = lswp_pkg::S_IDLE;
         end
      endcase
   end

   `ASSERT_RST(a_load_then_exec, clock, reset, cmd.load |=> cmd.exec)
   `ASSERT_RST(a_exec_then_resp, clock, reset, cmd.exec |=> cmd.respond)
   `ASSERT_RST(a_resp_then_free, clock, reset, cmd.respond |=> !busy && !cmd.respond)
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy)

endmodule
`default_nettype wire

// ----- hdl/lswp_dp.sv -----
// stack store, fill counter, capacity register and result registers
`default_nettype none
`include "assert_macros.svh"
module lswp_dp (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  lswp_pkg::ctrl_cmd_type          cmd,
   input  wire  [lswp_pkg::REQ_BITS-1:0]         req_type,
   input  wire  signed [lswp_pkg::DATA_BITS-1:0] req_push_value,
   input  wire  [lswp_pkg::POS_BITS-1:0]         req_position,
   input  wire                                   cap_write,
   input  wire  [lswp_pkg::CAP_BITS-1:0]         cap_data,
   output logic signed [lswp_pkg::DATA_BITS-1:0] rsp_read_value,
   output logic [lswp_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [lswp_pkg::CNT_BITS-1:0]         rsp_count,
   output logic                                  rsp_full_res,
   output logic                                  rsp_empty_res,
   output logic signed [lswp_pkg::DATA_BITS-1:0] rsp_top_value
);

   logic [lswp_pkg::DATA_BITS-1:0] mem [lswp_pkg::DEPTH];

   lswp_pkg::req_code_type         req_ff;
   logic [lswp_pkg::DATA_BITS-1:0] push_ff;
   logic [lswp_pkg::POS_BITS-1:0]  pos_ff;
   logic [lswp_pkg::CNT_BITS-1:0]  fill_ff;
   logic [lswp_pkg::CNT_BITS-1:0]  fill_in;
   logic [lswp_pkg::CAP_BITS-1:0]  cap_ff;
   lswp_pkg::status_code_type      status_ff;
   lswp_pkg::status_code_type      status_in;
   logic                           rd_ok_ff;
   logic                           rd_ok_in;
   logic                           top_push_ff;
   logic                           top_push_in;
   logic [lswp_pkg::DATA_BITS-1:0] rd_a_ff;
   logic [lswp_pkg::DATA_BITS-1:0] rd_b_ff;

   logic [lswp_pkg::CNT_BITS-1:0]  cap_eff;
   logic                           wr_en;
   logic [lswp_pkg::CNT_BITS-1:0]  addr_a_full;
   logic [lswp_pkg::CNT_BITS-1:0]  addr_b_full;
   logic [lswp_pkg::ADDR_BITS-1:0] addr_a;
   logic [lswp_pkg::ADDR_BITS-1:0] addr_b;
   logic [lswp_pkg::ADDR_BITS-1:0] wr_addr;

   // capacity clamped to 1..depth
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = lswp_pkg::CNT_BITS'(1);
      end else if (32'(cap_ff) > lswp_pkg::DEPTH) begin
         cap_eff = lswp_pkg::CNT_BITS'(lswp_pkg::DEPTH);
      end else begin
         cap_eff = lswp_pkg::CNT_BITS'(cap_ff);
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      status_in   = lswp_pkg::ST_OK;
      rd_ok_in    = 1'b0;
      top_push_in = 1'b0;
      wr_en       = 1'b0;
      addr_a_full = fill_ff - lswp_pkg::CNT_BITS'(1);
      case (req_ff)
         lswp_pkg::REQ_PUSH: begin
            if (fill_ff >= cap_eff) begin
               status_in = lswp_pkg::ST_OVERFLOW;
            end else begin
               wr_en       = 1'b1;
               top_push_in = 1'b1;
               fill_in     = fill_ff + lswp_pkg::CNT_BITS'(1);
            end
         end
         lswp_pkg::REQ_POP: begin
            if (fill_ff == '0) begin
               status_in = lswp_pkg::ST_UNDERFLOW;
            end else begin
               rd_ok_in = 1'b1;
               fill_in  = fill_ff - lswp_pkg::CNT_BITS'(1);
            end
         end
         lswp_pkg::REQ_PEEK: begin
            if (pos_ff == '0 || 32'(pos_ff) > 32'(fill_ff)) begin
               status_in = lswp_pkg::ST_BAD_POS;
            end else begin
               rd_ok_in    = 1'b1;
               addr_a_full = fill_ff - lswp_pkg::CNT_BITS'(pos_ff);
            end
         end
         default: begin
            status_in = lswp_pkg::ST_OK;
         end
      endcase
      addr_b_full = fill_in - lswp_pkg::CNT_BITS'(1);
   end

   assign addr_a  = addr_a_full[lswp_pkg::ADDR_BITS-1:0];
   assign addr_b  = addr_b_full[lswp_pkg::ADDR_BITS-1:0];
   assign wr_addr = fill_ff[lswp_pkg::ADDR_BITS-1:0];

   // stack store
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_en) begin
            mem[wr_addr] <= push_ff;
         end
         rd_a_ff <= mem[addr_a];
         rd_b_ff <= mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= lswp_pkg::req_code_type'(req_type);
         push_ff <= req_push_value;
         pos_ff  <= req_position;
      end
      if (cmd.exec) begin
         status_ff   <= status_in;
         rd_ok_ff    <= rd_ok_in;
         top_push_ff <= top_push_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cap_ff  <= lswp_pkg::CAP_BITS'(lswp_pkg::DEPTH);
      end else begin
         if (cmd.exec) begin
            fill_ff <= fill_in;
         end
         if (cap_write) begin
            cap_ff <= cap_data;
         end
      end
   end

   assign rsp_read_value = rd_ok_ff ? rd_a_ff : '0;
   assign rsp_status     = status_ff;
   assign rsp_count      = fill_ff;
   assign rsp_full_res   = fill_ff >= cap_eff;
   assign rsp_empty_res  = fill_ff == '0;
   always_comb begin
      if (fill_ff == '0) begin
         rsp_top_value = '1;
      end else if (top_push_ff) begin
         rsp_top_value = push_ff;
      end else begin
         rsp_top_value = rd_b_ff;
      end
   end

   `ASSERT_RST(a_fill_bound, clock, reset, 32'(fill_ff) <= lswp_pkg::DEPTH)
   `ASSERT_RST(a_fill_hold, clock, reset, !cmd.exec |=> $stable(fill_ff))
   `ASSERT_RST(a_push_room, clock, reset, (cmd.exec && wr_en) |-> (fill_ff < cap_eff))

endmodule
`default_nettype wire
